FILE: rtl/pursuit_lookahead_search_top_macros.svh
// ----------------------------------------------------------------------------
// Pursuit lookahead search: assertion macros
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PURSUIT_LOOKAHEAD_SEARCH_TOP_MACROS_SVH
`define PURSUIT_LOOKAHEAD_SEARCH_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLS_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pls_pkg.sv
// ----------------------------------------------------------------------------
// Pursuit lookahead search: package
// Transfer types, operation codes, register map and sequencer constants.
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam int MAX_POINTS = 16;
    localparam int PADDR_W    = 3;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register index taken from paddr[2].
    localparam logic REG_PATH_LENGTH = 1'b0;

    localparam logic [16:0] FRAC_ONE   = 17'd65536;
    localparam int          SQRT_STEPS = 64;
    localparam int          DIV_STEPS  = 16;
    localparam logic [3:0]  MAC_LAST   = 4'd13;

    typedef struct packed {
        logic               opcode;
        logic [3:0]         point_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] robot_x;
        logic signed [31:0] robot_y;
        logic [30:0]        lookahead_radius;
    } pls_req_t;

    typedef struct packed {
        logic               found;
        logic signed [31:0] look_x;
        logic signed [31:0] look_y;
        logic [3:0]         hit_segment;
        logic [16:0]        hit_fraction;
    } pls_rsp_t;

endpackage

FILE: rtl/pursuit_lookahead_search_top.sv
// ----------------------------------------------------------------------------
// Pursuit lookahead search
// Waypoint path store with a circle/segment lookahead search run on one
// shared multiply-accumulate unit, a radix-4 square root and a divider.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  req      in         req_valid/req_stall  pls_req_t: load or query
//  rsp      out        rsp_valid/rsp_stall  pls_rsp_t: one result per item
//  apb      in         psel/penable/pready  path_length at byte address 0
//
//  A query scans up to 15 segments, each paced mostly by the 64-step square root.
//  Reset clears progress, path_length and the output register; the waypoint
//  stores are not cleared. A stalled result holds the block in its final state
//  while the output register is full; no item is taken while a query runs.
`include "pursuit_lookahead_search_top_macros.svh"

module pursuit_lookahead_search_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  pls_pkg::pls_req_t           req_data,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output pls_pkg::pls_rsp_t           rsp_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pls_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import pls_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_A, S_RD_B, S_RD_C, S_SCALE, S_MAC, S_CHECK, S_SQRT,
        S_ROOT, S_DIV, S_PROG, S_PX, S_PY, S_NEXT, S_DONE
    } state_t;

    localparam logic [32:0] SCALE_LIM = 33'h0_4000_0000;

    // Control state
    state_t      state_reg;
    logic [3:0]  seg_reg;
    logic [3:0]  prog_seg_reg;
    logic [16:0] prog_frac_reg;
    logic [4:0]  path_length_reg;
    logic [3:0]  mstep_reg;
    logic [5:0]  cnt_reg;
    logic        rsp_valid_reg;
    pls_rsp_t    rsp_data_reg;
    pls_rsp_t    res_reg;

    // Datapath
    logic signed [31:0]  mem_x [MAX_POINTS];
    logic signed [31:0]  mem_y [MAX_POINTS];
    logic signed [31:0]  rd_x_reg, rd_y_reg;
    logic signed [31:0]  rx_reg, ry_reg, ex_reg, ey_reg;
    logic [30:0]         rr_reg;
    logic signed [32:0]  dxr_reg, dyr_reg, fxr_reg, fyr_reg;
    logic signed [31:0]  dx_reg, dy_reg, fx_reg, fy_reg;
    logic [30:0]         r_reg;
    logic signed [127:0] acc_reg;
    logic [61:0]         a_reg;
    logic signed [62:0]  g_reg;
    logic signed [63:0]  c_reg;
    logic [127:0]        hsh_reg;
    logic [64:0]         rem_reg;
    logic [63:0]         root_reg;
    logic [61:0]         dvr_reg;
    logic [14:0]         q_reg;
    logic [16:0]         frac_reg;

    logic        req_accept;
    logic        rsp_free;
    logic        cfg_write;
    logic [4:0]  len;
    logic [3:0]  rd_addr;

    always_comb
    begin
        len = (path_length_reg > 5'(MAX_POINTS)) ? 5'(MAX_POINTS) : path_length_reg;
    end

    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_data   = rsp_data_reg;
    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign prdata     = (paddr[2] == REG_PATH_LENGTH) ? {27'd0, path_length_reg} : 32'd0;
    assign rd_addr    = (state_reg == S_RD_B) ? seg_reg + 4'd1 : seg_reg;

    // Scaling of the segment and circle terms
    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        mag33 = v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic signed [31:0] shrink(input logic signed [32:0] v,
                                                  input logic [1:0] sh);
        logic [32:0] m;
        logic [32:0] q;
        m = mag33(v);
        q = m >> sh;
        shrink = v[32] ? $signed(32'd0 - q[31:0]) : $signed(q[31:0]);
    endfunction

    logic [32:0] m_max;
    logic [1:0]  sh;

    always_comb
    begin
        m_max = {2'b00, rr_reg};
        if (mag33(dxr_reg) > m_max) m_max = mag33(dxr_reg);
        if (mag33(dyr_reg) > m_max) m_max = mag33(dyr_reg);
        if (mag33(fxr_reg) > m_max) m_max = mag33(fxr_reg);
        if (mag33(fyr_reg) > m_max) m_max = mag33(fyr_reg);
        if (m_max <= SCALE_LIM)
            sh = 2'd0;
        else if ((m_max >> 1) <= SCALE_LIM)
            sh = 2'd1;
        else
            sh = 2'd2;
    end

    // Shared multiplier and accumulator
    logic [62:0]         g_mag;
    logic [63:0]         c_mag;
    logic signed [32:0]  op_a, op_b;
    logic [6:0]          shamt;
    logic                mac_clr, mac_sub;
    logic signed [65:0]  prod;
    logic signed [127:0] term;
    logic signed [127:0] acc_next;

    assign g_mag = g_reg[62] ? 63'(-g_reg) : 63'(g_reg);
    assign c_mag = c_reg[63] ? 64'(-c_reg) : 64'(c_reg);

    always_comb
    begin
        op_a    = {dx_reg[31], dx_reg};
        op_b    = {dx_reg[31], dx_reg};
        shamt   = 7'd0;
        mac_clr = 1'b0;
        mac_sub = 1'b0;
        if (state_reg == S_PX)
        begin
            op_a = {16'd0, frac_reg};
            op_b = dxr_reg;
        end
        else if (state_reg == S_PY)
        begin
            op_a = {16'd0, frac_reg};
            op_b = dyr_reg;
        end
        else
        begin
            case (mstep_reg)
                4'd0:
                begin
                    mac_clr = 1'b1;
                end
                4'd1:
                begin
                    op_a = {dy_reg[31], dy_reg};
                    op_b = {dy_reg[31], dy_reg};
                end
                4'd2:
                begin
                    op_a    = {fx_reg[31], fx_reg};
                    mac_clr = 1'b1;
                end
                4'd3:
                begin
                    op_a = {fy_reg[31], fy_reg};
                    op_b = {dy_reg[31], dy_reg};
                end
                4'd4:
                begin
                    op_a    = {fx_reg[31], fx_reg};
                    op_b    = {fx_reg[31], fx_reg};
                    mac_clr = 1'b1;
                end
                4'd5:
                begin
                    op_a = {fy_reg[31], fy_reg};
                    op_b = {fy_reg[31], fy_reg};
                end
                4'd6:
                begin
                    op_a    = {2'b00, r_reg};
                    op_b    = {2'b00, r_reg};
                    mac_sub = 1'b1;
                end
                4'd7:
                begin
                    op_a    = {2'b00, g_mag[30:0]};
                    op_b    = {2'b00, g_mag[30:0]};
                    mac_clr = 1'b1;
                end
                4'd8:
                begin
                    op_a  = {2'b00, g_mag[30:0]};
                    op_b  = {2'b00, g_mag[61:31]};
                    shamt = 7'd32;
                end
                4'd9:
                begin
                    op_a  = {2'b00, g_mag[61:31]};
                    op_b  = {2'b00, g_mag[61:31]};
                    shamt = 7'd62;
                end
                4'd10:
                begin
                    op_a    = {2'b00, a_reg[30:0]};
                    op_b    = {2'b00, c_mag[30:0]};
                    mac_sub = !c_reg[63];
                end
                4'd11:
                begin
                    op_a    = {2'b00, a_reg[30:0]};
                    op_b    = {2'b00, c_mag[61:31]};
                    shamt   = 7'd31;
                    mac_sub = !c_reg[63];
                end
                4'd12:
                begin
                    op_a    = {2'b00, a_reg[61:31]};
                    op_b    = {2'b00, c_mag[30:0]};
                    shamt   = 7'd31;
                    mac_sub = !c_reg[63];
                end
                4'd13:
                begin
                    op_a    = {2'b00, a_reg[61:31]};
                    op_b    = {2'b00, c_mag[61:31]};
                    shamt   = 7'd62;
                    mac_sub = !c_reg[63];
                end
                default:
                begin
                    mac_clr = 1'b1;
                end
            endcase
        end
    end

    assign prod     = op_a * op_b;
    assign term     = 128'(prod) <<< shamt;
    assign acc_next = (mac_clr ? 128'sd0 : acc_reg) + (mac_sub ? -term : term);

    // Lookahead point: truncating division of the product by 65536
    logic signed [65:0] prod_adj;
    logic signed [31:0] base_pt;
    logic signed [31:0] look_pt;

    assign prod_adj = prod + (prod[65] ? 66'sd65535 : 66'sd0);
    assign base_pt  = (state_reg == S_PY) ? ey_reg : ex_reg;
    assign look_pt  = base_pt + $signed(prod_adj[47:16]);

    // Square root step, two radicand bits per cycle
    logic [66:0] rem_sh;
    logic [66:0] trial;
    logic        sq_take;

    assign rem_sh  = {rem_reg, hsh_reg[127:126]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign sq_take = (rem_sh >= trial);

    // Root selection: exit root first, then entry root
    logic signed [64:0] s_ext, g_ext, a_ext, n1, n2, n_sel;
    logic               ok1, ok2;

    assign s_ext = $signed({2'b00, root_reg[62:0]});
    assign g_ext = 65'(g_reg);
    assign a_ext = $signed({3'b000, a_reg});
    assign n1    = s_ext - g_ext;
    assign n2    = -g_ext - s_ext;
    assign ok1   = (n1 >= 0) && (n1 <= a_ext);
    assign ok2   = (n2 >= 0) && (n2 <= a_ext);
    assign n_sel = ok1 ? n1 : n2;

    // Fraction division step
    logic [62:0] dv_t;
    logic        dv_take;

    assign dv_t    = {dvr_reg, 1'b0};
    assign dv_take = (dv_t >= {1'b0, a_reg});

    logic [4:0] next_end;
    assign next_end = {1'b0, seg_reg} + 5'd2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            seg_reg         <= 4'd0;
            prog_seg_reg    <= 4'd0;
            prog_frac_reg   <= 17'd0;
            path_length_reg <= 5'd0;
            mstep_reg       <= 4'd0;
            cnt_reg         <= 6'd0;
            rsp_valid_reg   <= 1'b0;
            rsp_data_reg    <= '0;
            res_reg         <= '0;
        end
        else
        begin
            if (cfg_write && paddr[2] == REG_PATH_LENGTH)
                path_length_reg <= pwdata[4:0];
            // In the final state the output register is reloaded below instead.
            if (rsp_valid_reg && !rsp_stall && state_reg != S_DONE)
                rsp_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (req_accept)
                    begin
                        res_reg <= '0;
                        seg_reg <= prog_seg_reg;
                        if (req_data.opcode == OP_QUERY &&
                            ({1'b0, prog_seg_reg} + 5'd1) < len)
                            state_reg <= S_RD_A;
                        else
                            state_reg <= S_DONE;
                    end
                end
                S_RD_A:  state_reg <= S_RD_B;
                S_RD_B:  state_reg <= S_RD_C;
                S_RD_C:  state_reg <= S_SCALE;
                S_SCALE:
                begin
                    mstep_reg <= 4'd0;
                    state_reg <= S_MAC;
                end
                S_MAC:
                begin
                    mstep_reg <= mstep_reg + 4'd1;
                    if (mstep_reg == MAC_LAST)
                        state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    cnt_reg <= 6'd0;
                    if (a_reg == 62'd0 || acc_reg[127])
                        state_reg <= S_NEXT;
                    else
                        state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(SQRT_STEPS - 1))
                        state_reg <= S_ROOT;
                end
                S_ROOT:
                begin
                    cnt_reg <= 6'd0;
                    if (!ok1 && !ok2)
                        state_reg <= S_NEXT;
                    else if (n_sel[61:0] >= a_reg)
                        state_reg <= S_PROG;
                    else
                        state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(DIV_STEPS - 1))
                        state_reg <= S_PROG;
                end
                S_PROG:
                begin
                    if (seg_reg == prog_seg_reg && frac_reg < prog_frac_reg)
                        state_reg <= S_NEXT;
                    else
                        state_reg <= S_PX;
                end
                S_PX:
                begin
                    res_reg.look_x <= look_pt;
                    state_reg      <= S_PY;
                end
                S_PY:
                begin
                    res_reg.look_y       <= look_pt;
                    res_reg.found        <= 1'b1;
                    res_reg.hit_segment  <= seg_reg;
                    res_reg.hit_fraction <= frac_reg;
                    prog_seg_reg         <= seg_reg;
                    prog_frac_reg        <= frac_reg;
                    state_reg            <= S_DONE;
                end
                S_NEXT:
                begin
                    seg_reg <= seg_reg + 4'd1;
                    if (next_end < len)
                        state_reg <= S_RD_A;
                    else
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (rsp_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        rsp_data_reg  <= res_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept && req_data.opcode == OP_LOAD)
        begin
            mem_x[req_data.point_index] <= req_data.point_x;
            mem_y[req_data.point_index] <= req_data.point_y;
        end
        rd_x_reg <= mem_x[rd_addr];
        rd_y_reg <= mem_y[rd_addr];

        if (req_accept)
        begin
            rx_reg <= req_data.robot_x;
            ry_reg <= req_data.robot_y;
            rr_reg <= req_data.lookahead_radius;
        end

        case (state_reg)
            S_RD_B:
            begin
                ex_reg <= rd_x_reg;
                ey_reg <= rd_y_reg;
            end
            S_RD_C:
            begin
                dxr_reg <= 33'(rd_x_reg) - 33'(ex_reg);
                dyr_reg <= 33'(rd_y_reg) - 33'(ey_reg);
                fxr_reg <= 33'(ex_reg) - 33'(rx_reg);
                fyr_reg <= 33'(ey_reg) - 33'(ry_reg);
            end
            S_SCALE:
            begin
                dx_reg <= shrink(dxr_reg, sh);
                dy_reg <= shrink(dyr_reg, sh);
                fx_reg <= shrink(fxr_reg, sh);
                fy_reg <= shrink(fyr_reg, sh);
                r_reg  <= rr_reg >> sh;
            end
            S_MAC:
            begin
                acc_reg <= acc_next;
                if (mstep_reg == 4'd2)
                    a_reg <= acc_reg[61:0];
                if (mstep_reg == 4'd4)
                    g_reg <= acc_reg[62:0];
                if (mstep_reg == 4'd7)
                    c_reg <= acc_reg[63:0];
            end
            S_CHECK:
            begin
                hsh_reg  <= acc_reg;
                rem_reg  <= 65'd0;
                root_reg <= 64'd0;
            end
            S_SQRT:
            begin
                hsh_reg  <= {hsh_reg[125:0], 2'b00};
                rem_reg  <= sq_take ? 65'(rem_sh - trial) : rem_sh[64:0];
                root_reg <= {root_reg[62:0], sq_take};
            end
            S_ROOT:
            begin
                dvr_reg  <= n_sel[61:0];
                q_reg    <= 15'd0;
                frac_reg <= FRAC_ONE;
            end
            S_DIV:
            begin
                dvr_reg  <= dv_take ? 62'(dv_t - {1'b0, a_reg}) : dv_t[61:0];
                q_reg    <= {q_reg[13:0], dv_take};
                frac_reg <= {1'b0, q_reg[14:0], dv_take};
            end
            default:
            begin
            end
        endcase
    end

    `PLS_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, state_reg != S_IDLE, "request not taken up")
    `PLS_ASSERT_SAME(a_nohit_zero, rsp_valid && !rsp_data.found, rsp_data.look_x == 32'sd0 && rsp_data.look_y == 32'sd0 && rsp_data.hit_segment == 4'd0 && rsp_data.hit_fraction == 17'd0, "miss with payload")
    `PLS_ASSERT_SAME(a_frac_range, rsp_valid && rsp_data.found, rsp_data.hit_fraction <= FRAC_ONE, "fraction out of range")
    `PLS_ASSERT_SAME(a_mac_bounded, state_reg == S_MAC, mstep_reg <= MAC_LAST, "MAC step overrun")

endmodule

FILE: bench/pursuit_lookahead_search_top_tb.sv
// ----------------------------------------------------------------------------
// Pursuit lookahead search: testbench
// Loads waypoint paths, sets the path length over the configuration port and
// sends lookahead queries. Each result is checked field by field against a
// circle/segment intersection predictor, under random idling on both sides.
// ----------------------------------------------------------------------------
module pursuit_lookahead_search_top_tb;
    import pls_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    pls_req_t          req_data;
    logic              rsp_valid;
    logic              rsp_stall;
    pls_rsp_t          rsp_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // Predictor state.
    logic signed [31:0] path_x [MAX_POINTS];
    logic signed [31:0] path_y [MAX_POINTS];
    int                 prog_seg;
    longint             prog_frac;
    int                 path_len;

    pls_rsp_t           pending_results[$];
    int                 error_count;
    int                 load_count;
    int                 query_count;
    int                 hit_count;
    int                 gap_pct;
    int                 stall_pct;

    pursuit_lookahead_search_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_data (req_data),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_data (rsp_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 4000000);
        $display("TEST FAILED");
        $finish;
    end

    function automatic longint shrink(longint v, int sh);
        if (v < 0)
            return -((-v) >>> sh);
        return v >>> sh;
    endfunction

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Works out the result of one item and moves the predictor state on.
    function automatic pls_rsp_t lookahead_result(pls_req_t q);
        pls_rsp_t           res;
        int                 len;
        longint             ex, ey, lx, ly, dxr, dyr, dx, dy, fx, fy, r, a, g, c, m;
        longint             fr;
        int                 sh;
        logic signed [127:0] gw, aw, cw, h, sw, n;
        logic [127:0]       cand;
        bit                 ok;
        res = '0;
        if (q.opcode == OP_LOAD)
        begin
            path_x[q.point_index] = q.point_x;
            path_y[q.point_index] = q.point_y;
            return res;
        end
        len = (path_len > MAX_POINTS) ? MAX_POINTS : path_len;
        for (int i = prog_seg; i + 1 < len; i++)
        begin
            ex  = path_x[i];
            ey  = path_y[i];
            lx  = path_x[i+1];
            ly  = path_y[i+1];
            dxr = lx - ex;
            dyr = ly - ey;
            fx  = ex - longint'(q.robot_x);
            fy  = ey - longint'(q.robot_y);
            r   = longint'({1'b0, q.lookahead_radius});
            m = magnitude(dxr);
            if (magnitude(dyr) > m) m = magnitude(dyr);
            if (magnitude(fx) > m) m = magnitude(fx);
            if (magnitude(fy) > m) m = magnitude(fy);
            if (r > m) m = r;
            sh = 0;
            while ((m >>> sh) > (64'sd1 <<< 30))
                sh++;
            dx = shrink(dxr, sh);
            dy = shrink(dyr, sh);
            fx = shrink(fx, sh);
            fy = shrink(fy, sh);
            r  = shrink(r, sh);
            a = dx * dx + dy * dy;
            if (a == 0)
                continue;
            g  = fx * dx + fy * dy;
            c  = fx * fx + fy * fy - r * r;
            gw = g;
            aw = a;
            cw = c;
            h  = gw * gw - aw * cw;
            if (h < 0)
                continue;
            cand = '0;
            for (int b = 62; b >= 0; b--)
            begin
                cand[b] = 1'b1;
                if (cand * cand > h)
                    cand[b] = 1'b0;
            end
            sw = cand;
            // The exit root is tried first; the entry root only if it misses.
            n  = sw - gw;
            ok = (n >= 0 && n <= aw);
            if (!ok)
            begin
                n  = -gw - sw;
                ok = (n >= 0 && n <= aw);
            end
            if (!ok)
                continue;
            fr = (n >= aw) ? 65536 : longint'((n * 65536) / aw);
            if (i == prog_seg && fr < prog_frac)
                continue;
            prog_seg         = i;
            prog_frac        = fr;
            res.found        = 1'b1;
            res.look_x       = 32'(ex + (fr * dxr) / 65536);
            res.look_y       = 32'(ey + (fr * dyr) / 65536);
            res.hit_segment  = 4'(i);
            res.hit_fraction = 17'(fr);
            return res;
        end
        return res;
    endfunction

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer");
                error_count++;
            end
            else
            begin
                pls_rsp_t e;
                e = pending_results.pop_front();
                if (rsp_data.found !== e.found)
                begin
                    $error("found: expected %0d actual %0d", e.found, rsp_data.found);
                    error_count++;
                end
                if (rsp_data.look_x !== e.look_x)
                begin
                    $error("look_x: expected %0d actual %0d", e.look_x, rsp_data.look_x);
                    error_count++;
                end
                if (rsp_data.look_y !== e.look_y)
                begin
                    $error("look_y: expected %0d actual %0d", e.look_y, rsp_data.look_y);
                    error_count++;
                end
                if (rsp_data.hit_segment !== e.hit_segment)
                begin
                    $error("hit_segment: expected %0d actual %0d", e.hit_segment,
                           rsp_data.hit_segment);
                    error_count++;
                end
                if (rsp_data.hit_fraction !== e.hit_fraction)
                begin
                    $error("hit_fraction: expected %0d actual %0d", e.hit_fraction,
                           rsp_data.hit_fraction);
                    error_count++;
                end
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_item(pls_req_t q);
        req_data  <= q;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(req_valid && !req_stall));
        pending_results.push_back(lookahead_result(q));
        if (q.opcode == OP_LOAD)
            load_count++;
        else
        begin
            query_count++;
            if (pending_results[$].found)
                hit_count++;
        end
        if ($urandom_range(99) < gap_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic send_load(int idx, int x, int y);
        pls_req_t q;
        q             = pls_req_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        q.opcode      = OP_LOAD;
        q.point_index = 4'(idx);
        q.point_x     = x;
        q.point_y     = y;
        send_item(q);
    endtask

    task automatic send_query(int x, int y, logic [30:0] rad);
        pls_req_t q;
        q                  = pls_req_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        q.opcode           = OP_QUERY;
        q.robot_x          = x;
        q.robot_y          = y;
        q.lookahead_radius = rad;
        send_item(q);
    endtask

    // Holds the sender off until every result is in, then lets the block settle.
    task automatic drain;
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_path_length(int value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_PATH_LENGTH, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        path_len = value & 31;
    endtask

    function automatic int rand_scaled(int bits);
        int v;
        v = $urandom;
        return v >>> (32 - bits);
    endfunction

    task automatic test_straight_path;
        write_path_length(MAX_POINTS);
        for (int k = 0; k < MAX_POINTS; k++)
            send_load(k, (k * 10) <<< 16, 0);
        send_query(0, 0, 31'(5 <<< 16));                    // mid first segment
        send_query(0, 0, 31'(4 <<< 16));                    // exit root behind progress
        send_query(32'(25 <<< 16), 32'(100 <<< 16), 31'(1 <<< 16)); // no real roots
        send_query(32'(25 <<< 16), 0, 0);                   // zero radius on the path
        send_query(32'(30 <<< 16), 0, 31'(10 <<< 16));      // segment end exactly
        send_query(0, 0, 31'h7FFF_FFFF);                    // circle swallows the path
        send_load(3, 30 <<< 16, 0);
        send_load(4, 30 <<< 16, 0);                         // degenerate segment
        send_query(32'(30 <<< 16), 0, 31'(15 <<< 16));
    endtask

    task automatic test_extremes;
        write_path_length(31);                              // oversized length
        send_load(0, 32'h8000_0000, 32'h8000_0000);
        send_load(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_load(15, 32'h7FFF_FFFF, 32'h8000_0000);
        send_query(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_query(32'h7FFF_FFFF, 32'h8000_0000, 31'h4000_0000);
        write_path_length(0);
        send_query(0, 0, 31'h7FFF_FFFF);
        write_path_length(1);
        send_query(0, 0, 31'h7FFF_FFFF);
    endtask

    task automatic test_random_paths(int count);
        int bits;
        int cx;
        int cy;
        int k;
        write_path_length($urandom_range(2, 31));
        for (int n = 0; n < count; n++)
        begin
            if (n % 60 == 59)
                write_path_length($urandom_range(0, 31));
            bits = $urandom_range(8, 31);
            k    = $urandom_range(MAX_POINTS - 1);
            if ($urandom_range(9) == 0)
            begin
                if ($urandom_range(1))
                    send_load(k, $urandom, $urandom);
                else
                    send_query($urandom, $urandom, 31'($urandom));
            end
            else if ($urandom_range(99) < 30)
                send_load(k, 32'(path_x[k > 0 ? k - 1 : 0]) + rand_scaled(bits),
                          32'(path_y[k > 0 ? k - 1 : 0]) + rand_scaled(bits));
            else
            begin
                // Robot near a stored waypoint, radius of the same order as the spacing.
                cx = path_x[k] + rand_scaled(bits);
                cy = path_y[k] + rand_scaled(bits);
                send_query(cx, cy, 31'($urandom >> (32 - (bits > 31 ? 31 : bits))));
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req_data    = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        prog_seg    = 0;
        prog_frac   = 0;
        path_len    = 0;
        error_count = 0;
        load_count  = 0;
        query_count = 0;
        hit_count   = 0;
        gap_pct     = 0;
        stall_pct   = 0;
        for (int k = 0; k < MAX_POINTS; k++)
        begin
            path_x[k] = '0;
            path_y[k] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct   = 29;
        stall_pct = 71;
        test_straight_path();
        test_extremes();
        test_random_paths(170);
        gap_pct   = 71;
        stall_pct = 29;
        test_random_paths(170);
        gap_pct   = 0;
        stall_pct = 0;
        test_random_paths(170);
        drain();
        repeat (20) @(posedge clk);

        $display("Covered %0d waypoint loads and %0d lookahead queries, %0d of them hits,",
                 load_count, query_count, hit_count);
        $display("over path lengths from 0 to 31 and coordinate scales up to full range.");
        if (error_count == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
